### design/icrr_pkg.sv
`default_nettype none
package icrr_pkg;
    localparam int MaxCons    = 8;
    localparam int MaxReads   = 32;
    localparam int MaxConLen  = 512;
    localparam int MaxReadLen = 256;

    localparam int ConIdxW  = $clog2(MaxCons);
    localparam int ReadIdxW = $clog2(MaxReads);
    localparam int ConPosW  = $clog2(MaxConLen);
    localparam int ReadPosW = $clog2(MaxReadLen);
    localparam int ConCntW  = $clog2(MaxCons + 1);
    localparam int ReadCntW = $clog2(MaxReads + 1);
    localparam int ConLenW  = $clog2(MaxConLen + 1);
    localparam int ReadLenW = $clog2(MaxReadLen + 1);
    localparam int DistW    = 31;
    localparam int ScoreW   = 37;

    localparam logic [DistW-1:0]  NoFitDist = 31'h7fffffff;
    localparam logic [ScoreW-1:0] ScoreOnes = '1;

    localparam logic [1:0] ReqCons  = 2'd0;
    localparam logic [1:0] ReqRead  = 2'd1;
    localparam logic [1:0] ReqStart = 2'd2;
    localparam logic [1:0] ReqIdle  = 2'd3;   // reserved kind, ignored

    // front-to-back command
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] base;
        logic [6:0] quality;
        logic       seq_last;
    } t_cmd;

    // result item
    typedef struct packed {
        logic [4:0]       read_index;
        logic [2:0]       chosen;
        logic [DistW-1:0] distance;
        logic [8:0]       offset;
        logic             no_fit;
        logic             last;
    } t_res;
endpackage
`default_nettype wire

### design/icrr_front.sv
`default_nettype none
// Accepts requests, drops reserved kinds, and queues the rest.
module icrr_front
    import icrr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cmd      o_cmd
);
    localparam int Depth = 4;
    localparam int PtrW  = 2;

    t_cmd            r_q [Depth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [PtrW:0]   r_cnt;
    logic            w_push, w_pop;

    assign o_ready = (r_cnt != (PtrW+1)'(Depth));
    assign w_push  = i_valid && o_ready && (i_cmd.kind != ReqIdle);
    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_cmd   = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(w_push) - (PtrW+1)'(w_pop);
        end
    end
endmodule
`default_nettype wire

### design/icrr_back.sv
`default_nettype none
// Loads sequences and runs the sliding scoring sequencer.
module icrr_back
    import icrr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_res
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PAIR  = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_ACC   = 10'b0000001000,
        S_OFS   = 10'b0000010000,
        S_SAVE  = 10'b0000100000,
        S_SCR   = 10'b0001000000,
        S_SCRA  = 10'b0010000000,
        S_OUTR  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    localparam int ConAW  = ConIdxW + ConPosW;
    localparam int ReadAW = ReadIdxW + ReadPosW;
    localparam int TabAW  = ConIdxW + ReadIdxW;

    // memories
    logic [3:0]          m_con  [MaxCons*MaxConLen];
    logic [3:0]          m_rb   [MaxReads*MaxReadLen];
    logic [6:0]          m_rq   [MaxReads*MaxReadLen];
    logic [DistW-1:0]    m_dist [MaxCons*MaxReads];
    logic [ConPosW-1:0]  m_ofs  [MaxCons*MaxReads];
    logic [ConLenW-1:0]  r_clen [MaxCons];
    logic [ReadLenW-1:0] r_rlen [MaxReads];

    t_state              r_st;
    logic [ConCntW-1:0]  r_ncon;
    logic [ReadCntW-1:0] r_nrd;
    logic [ConLenW-1:0]  r_cfill;
    logic [ReadLenW-1:0] r_rfill;

    logic [ConIdxW-1:0]  r_c;
    logic [ReadIdxW-1:0] r_j;
    logic [ConLenW-1:0]  r_k;
    logic [ReadLenW-1:0] r_l;
    logic [ConLenW-1:0]  r_cl;
    logic [ReadLenW-1:0] r_rl;
    logic [DistW-1:0]    r_sum, r_best;
    logic [ConPosW-1:0]  r_where;
    logic [3:0]          r_cb, r_rbd;
    logic [6:0]          r_qd;
    logic [DistW-1:0]    r_da, r_dz;
    logic [ScoreW-1:0]   r_score, r_bscore;
    logic [ConIdxW-1:0]  r_chosen;
    logic                r_ov;
    t_res                r_res;
    logic [ConPosW-1:0]  r_ofsd;

    logic [ConLenW-1:0]  w_pos;
    logic                w_last_k, w_last_j, w_last_c;
    logic [ConCntW-1:0]  w_slots;
    logic [DistW-1:0]    w_diff;
    logic                w_emit;

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign w_pos   = r_k + ConLenW'(r_l);
    assign w_slots = (r_ncon == '0) ? ConCntW'(1) : r_ncon;
    assign w_last_j = (ReadCntW'(r_j) + 1'b1 == r_nrd);
    assign w_last_c = (ConCntW'(r_c) + 1'b1 == w_slots);
    assign w_last_k = (r_k + ConLenW'(r_rl) == r_cl);
    assign w_diff  = (r_da >= r_dz) ? (r_da - r_dz) : (r_dz - r_da);
    assign w_emit  = (r_st == S_OUT) && (r_l != '0) && (!r_ov || i_ready);

    // sequence loading writes
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_cmd.kind == ReqCons &&
            r_ncon != ConCntW'(MaxCons) && r_cfill != ConLenW'(MaxConLen))
            m_con[{r_ncon[ConIdxW-1:0], r_cfill[ConPosW-1:0]}] <= i_cmd.base;
        if (i_valid && o_ready && i_cmd.kind == ReqRead &&
            r_nrd != ReadCntW'(MaxReads) && r_rfill != ReadLenW'(MaxReadLen)) begin
            m_rb[{r_nrd[ReadIdxW-1:0], r_rfill[ReadPosW-1:0]}] <= i_cmd.base;
            m_rq[{r_nrd[ReadIdxW-1:0], r_rfill[ReadPosW-1:0]}] <= i_cmd.quality;
        end
    end

    // memory reads and table writes
    always_ff @(posedge i_clk) begin
        r_cb  <= m_con[ConAW'({r_c, w_pos[ConPosW-1:0]})];
        r_rbd <= m_rb[ReadAW'({r_j, r_l[ReadPosW-1:0]})];
        r_qd  <= m_rq[ReadAW'({r_j, r_l[ReadPosW-1:0]})];
        r_da  <= m_dist[TabAW'({r_c, r_j})];
        r_dz  <= m_dist[TabAW'({ConIdxW'(0), r_j})];
        r_ofsd <= m_ofs[TabAW'({r_chosen, r_j})];
        if (r_st == S_SAVE) begin
            m_dist[TabAW'({r_c, r_j})] <= r_best;
            m_ofs[TabAW'({r_c, r_j})]  <= r_where;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ncon <= '0; r_nrd <= '0; r_cfill <= '0; r_rfill <= '0;
            r_ov <= 1'b0;
            r_bscore <= ScoreOnes;
        end else begin
            if (r_ov && i_ready && !w_emit) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_cmd.kind == ReqCons && r_ncon != ConCntW'(MaxCons)) begin
                            if (i_cmd.seq_last) begin
                                r_clen[r_ncon[ConIdxW-1:0]] <=
                                    (r_cfill == ConLenW'(MaxConLen)) ? r_cfill
                                                                      : r_cfill + 1'b1;
                                r_ncon <= r_ncon + 1'b1;
                                r_cfill <= '0;
                            end else if (r_cfill != ConLenW'(MaxConLen)) begin
                                r_cfill <= r_cfill + 1'b1;
                            end
                        end
                        if (i_cmd.kind == ReqRead && r_nrd != ReadCntW'(MaxReads)) begin
                            if (i_cmd.seq_last) begin
                                r_rlen[r_nrd[ReadIdxW-1:0]] <=
                                    (r_rfill == ReadLenW'(MaxReadLen)) ? r_rfill
                                                                        : r_rfill + 1'b1;
                                r_nrd <= r_nrd + 1'b1;
                                r_rfill <= '0;
                            end else if (r_rfill != ReadLenW'(MaxReadLen)) begin
                                r_rfill <= r_rfill + 1'b1;
                            end
                        end
                        if (i_cmd.kind == ReqStart) begin
                            r_c <= '0; r_j <= '0;
                            r_cfill <= '0; r_rfill <= '0;
                            // no reads: nothing to emit, batch is dropped
                            if (r_nrd != '0) r_st <= S_PAIR;
                            else r_ncon <= '0;
                        end
                    end
                end
                // set up one read/consensus pair
                S_PAIR: begin
                    r_cl <= (ConCntW'(r_c) < r_ncon) ? r_clen[r_c] : '0;
                    r_rl <= r_rlen[r_j];
                    r_k <= '0; r_l <= '0; r_sum <= '0;
                    r_best <= NoFitDist; r_where <= '0;
                    r_st <= S_OFS;
                end
                S_OFS: begin
                    if (ConLenW'(r_rl) > r_cl) r_st <= S_SAVE;
                    else if (r_rl == '0) begin
                        // empty read: every offset gives zero, first is 0
                        r_best <= '0; r_st <= S_SAVE;
                    end else r_st <= S_RD;
                end
                S_RD: begin
                    r_l <= r_l + 1'b1;
                    r_st <= S_ACC;
                end
                S_ACC: begin
                    if (r_cb != r_rbd) r_sum <= r_sum + DistW'(r_qd);
                    if (r_l == r_rl) begin
                        r_st <= S_SCR; // reused as offset-compare step
                    end else r_st <= S_RD;
                end
                S_SCR: begin
                    if (r_sum < r_best) begin
                        r_best <= r_sum; r_where <= r_k[ConPosW-1:0];
                    end
                    r_sum <= '0; r_l <= '0;
                    if (w_last_k) r_st <= S_SAVE;
                    else begin
                        r_k <= r_k + 1'b1; r_st <= S_RD;
                    end
                end
                S_SAVE: begin
                    if (w_last_j) begin
                        r_j <= '0;
                        if (w_last_c) begin
                            r_c <= ConIdxW'(1); r_chosen <= '0;
                            r_bscore <= ScoreOnes; r_score <= '0;
                            r_st <= (r_ncon > ConCntW'(1)) ? S_SCRA : S_OUTR;
                        end else begin
                            r_c <= r_c + 1'b1; r_st <= S_PAIR;
                        end
                    end else begin
                        r_j <= r_j + 1'b1; r_st <= S_PAIR;
                    end
                end
                // score: r_da/r_dz are registered in the cycle after the index is set
                S_SCRA: begin
                    if (r_l == '0) begin
                        r_l <= ReadLenW'(1);
                    end else begin
                        r_l <= '0;
                        if (w_last_j) begin
                            if (r_score + ScoreW'(w_diff) < r_bscore) begin
                                r_bscore <= r_score + ScoreW'(w_diff);
                                r_chosen <= r_c;
                            end
                            r_score <= '0; r_j <= '0;
                            if (ConCntW'(r_c) + 1'b1 == r_ncon) r_st <= S_OUTR;
                            else r_c <= r_c + 1'b1;
                        end else begin
                            r_score <= r_score + ScoreW'(w_diff);
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                // point the table read at the winner for this read
                S_OUTR: begin
                    r_cl <= (ConCntW'(r_chosen) < r_ncon) ? r_clen[r_chosen] : '0;
                    r_rl <= r_rlen[r_j];
                    r_c <= r_chosen;
                    r_l <= '0;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (r_l == '0) begin
                        r_l <= ReadLenW'(1); // wait for table read
                    end else if (w_emit) begin
                        r_ov <= 1'b1;
                        r_res.read_index <= 5'(r_j);
                        r_res.chosen <= 3'(r_chosen);
                        r_res.no_fit <= ConLenW'(r_rl) > r_cl;
                        r_res.distance <= (ConLenW'(r_rl) > r_cl) ? NoFitDist : r_da;
                        r_res.offset <= (ConLenW'(r_rl) > r_cl) ? 9'd0 : 9'(r_ofsd);
                        r_res.last <= w_last_j;
                        if (w_last_j) begin
                            r_ncon <= '0; r_nrd <= '0; r_st <= S_IDLE;
                        end else begin
                            r_j <= r_j + 1'b1; r_st <= S_OUTR;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### design/indel_consensus_realign_rank.sv
// Flow: a load request passes through a 4-entry queue to the loader; loads are
// taken at one per cycle while the back end is idle.
// Start: each read/consensus pair is set up and, when the read fits, every offset
// is scored base by base and compared; ranking then scores each consensus after
// the first; results go out one per read, held by output stall. One start at a time.
// Reset: synchronous active low clears counts, queue and handshake state.
`default_nettype none
module indel_consensus_realign_rank
    import icrr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // req_type, base, quality, pad
    input  wire logic        s_axis_tlast,  // seq_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // read_index, chosen_consensus,
                                            // best_distance, best_offset, no_fit, pad
    output logic             m_axis_tlast   // last
);
    t_cmd w_in, w_q;
    t_res w_res;
    logic w_qv, w_qr;

    assign w_in.kind     = s_axis_tdata[1:0];
    assign w_in.base     = s_axis_tdata[5:2];
    assign w_in.quality  = s_axis_tdata[12:6];
    assign w_in.seq_last = s_axis_tlast;

    icrr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_q)
    );

    icrr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_cmd(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {7'd0, w_res.no_fit, w_res.offset, w_res.distance,
                           w_res.chosen, w_res.read_index};
    assign m_axis_tlast = w_res.last;
endmodule
`default_nettype wire
